/* rtl/gsuf_pkg.sv */
`default_nettype none
package gsuf_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VERTEX_W = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned THR_W    = 24;

  localparam logic [THR_W-1:0] THR_MAX     = {THR_W{1'b1}};
  localparam logic [THR_W-1:0] MERGE_RESET = 24'd256;

  // Operation codes carried by an input item
  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_EDGE  = 2'd1,
    OP_FIND  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_FIND_A = 6'b000100,
    S_FIND_B = 6'b001000,
    S_DIV    = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

endpackage
`default_nettype wire

/* rtl/gsuf_div.sv */
`default_nettype none
module gsuf_div #(
  parameter int unsigned DIV_W = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gsuf_pkg::THR_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic [gsuf_pkg::THR_W-1:0] quotient_o
);
  import gsuf_pkg::*;

  localparam int unsigned CNT_W = $clog2(THR_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(THR_W - 1);

  logic [THR_W-1:0] quo_q, quo_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] diff;
  logic           ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[THR_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[THR_W-2:0], ge};
      rem_d = ge ? diff : rem_sh;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

/* rtl/graph_segment_union_find_core.sv */
`default_nettype none
// Start: clears one store entry per cycle, one for each active vertex.
// Edge: walks both parent chains, then a join waits on the serial divider.
// Find: walks one parent chain. Out-of-range and unused ops go straight to the response.
// One item at a time; parent-chain walks go through one store read port.
// Reset: control and merge_constant (256) clear at once; no vertex active.
module graph_segment_union_find_core #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gsuf_pkg::op_e                 op_i,
  input  logic [gsuf_pkg::VERTEX_W-1:0] vertex_a_i,
  input  logic [gsuf_pkg::VERTEX_W-1:0] vertex_b_i,
  input  logic [gsuf_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [gsuf_pkg::COUNT_W-1:0]  vertex_count_i,
  input  logic                          last_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          merged_o,
  output logic [gsuf_pkg::VERTEX_W-1:0] root_o,
  output logic [gsuf_pkg::COUNT_W-1:0]  component_size_o,
  output logic                          done_res_o,
  output logic                          status_o,
  input  logic                          cfg_we_i,
  input  logic [gsuf_pkg::THR_W-1:0]    cfg_wdata_i
);
  import gsuf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned MW = AW + CW + THR_W;

  state_e state_q, state_d;

  logic [CW-1:0]       active_q, active_d;
  logic [THR_W-1:0]    merge_c_q;
  logic                find_only_q, find_only_d;
  logic [AW-1:0]       vb_q, vb_d;
  logic [WEIGHT_W-1:0] w_q, w_d;
  logic                last_q, last_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       ra_q, ra_d;
  logic [CW-1:0]       sa_q, sa_d;
  logic [THR_W-1:0]    ta_q, ta_d;
  logic [AW-1:0]       nr_q, nr_d;
  logic [CW-1:0]       sz_q, sz_d;
  logic [CW-1:0]       idx_q, idx_d;

  logic                res_merged_q, res_merged_d;
  logic [AW-1:0]       res_root_q, res_root_d;
  logic [CW-1:0]       res_size_q, res_size_d;
  logic                res_status_q, res_status_d;

  logic                out_valid_q, out_valid_d;
  logic                out_merged_q;
  logic [VERTEX_W-1:0] out_root_q;
  logic [COUNT_W-1:0]  out_size_q;
  logic                out_done_q;
  logic                out_status_q;
  logic                out_load;

  // Union-find store: {parent, size, threshold} per vertex
  logic [MW-1:0] mem [MAX_VERTICES];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [MW-1:0] rdata_q;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  logic [AW-1:0]    rd_parent;
  logic [CW-1:0]    rd_size;
  logic [THR_W-1:0] rd_thr;

  logic [CW-1:0]    cnt_sat;
  logic             va_bad, vb_bad;
  logic             do_join;
  logic [THR_W:0]   thr_sum;
  logic [THR_W-1:0] thr_new;

  logic             div_start;
  logic             div_done;
  logic [THR_W-1:0] div_quo;

  assign rd_parent = rdata_q[MW-1 -: AW];
  assign rd_size   = rdata_q[THR_W +: CW];
  assign rd_thr    = rdata_q[THR_W-1:0];

  assign cnt_sat = (XW'(vertex_count_i) > XW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                               : CW'(vertex_count_i);
  assign va_bad  = XW'(vertex_a_i) >= XW'(active_q);
  assign vb_bad  = XW'(vertex_b_i) >= XW'(active_q);

  assign do_join = (ra_q != cur_q) && (THR_W'(w_q) <= ta_q) && (THR_W'(w_q) <= rd_thr);

  // Saturate weight plus size term
  assign thr_sum = (THR_W + 1)'(w_q) + (THR_W + 1)'(div_quo);
  assign thr_new = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];

  assign out_load = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  gsuf_div #(
    .DIV_W(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(merge_c_q),
    .divisor_i (sz_d),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    find_only_d  = find_only_q;
    vb_d         = vb_q;
    w_d          = w_q;
    last_d       = last_q;
    cur_d        = cur_q;
    ra_d         = ra_q;
    sa_d         = sa_q;
    ta_d         = ta_q;
    nr_d         = nr_q;
    sz_d         = sz_q;
    idx_d        = idx_q;
    res_merged_d = res_merged_q;
    res_root_d   = res_root_q;
    res_size_d   = res_size_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    div_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          vb_d         = AW'(vertex_b_i);
          w_d          = weight_i;
          last_d       = last_edge_i;
          res_merged_d = 1'b0;
          res_root_d   = '0;
          res_size_d   = '0;
          res_status_d = 1'b0;
          state_d      = S_RESP;
          unique case (op_i)
            OP_START: begin
              active_d = cnt_sat;
              idx_d    = '0;
              if (cnt_sat != '0) state_d = S_CLEAR;
            end
            OP_EDGE: begin
              if (va_bad || vb_bad) begin
                res_status_d = 1'b1;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = AW'(vertex_a_i);
                cur_d       = AW'(vertex_a_i);
                find_only_d = 1'b0;
                state_d     = S_FIND_A;
              end
            end
            OP_FIND: begin
              if (va_bad) begin
                res_status_d = 1'b1;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = AW'(vertex_a_i);
                cur_d       = AW'(vertex_a_i);
                find_only_d = 1'b1;
                state_d     = S_FIND_A;
              end
            end
            OP_NONE: begin
            end
          endcase
        end
      end

      // Reset one entry per cycle for the new graph
      S_CLEAR: begin
        we      = 1'b1;
        wr_addr = AW'(idx_q);
        wr_data = {AW'(idx_q), CW'(1), merge_c_q};
        if (idx_q == active_q - 1'b1) begin
          state_d = S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Walk vertex_a's parent chain
      S_FIND_A: begin
        if (rd_parent == cur_q) begin
          if (find_only_q) begin
            res_root_d = cur_q;
            res_size_d = rd_size;
            state_d    = S_RESP;
          end else begin
            ra_d    = cur_q;
            sa_d    = rd_size;
            ta_d    = rd_thr;
            rd_en   = 1'b1;
            rd_addr = vb_q;
            cur_d   = vb_q;
            state_d = S_FIND_B;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_parent;
          cur_d   = rd_parent;
        end
      end

      // Walk vertex_b's chain, then decide the join
      S_FIND_B: begin
        if (rd_parent == cur_q) begin
          if (do_join) begin
            we   = 1'b1;
            sz_d = sa_q + rd_size;
            if (sa_q > rd_size) begin
              nr_d    = ra_q;
              wr_addr = cur_q;
              wr_data = {ra_q, rd_size, rd_thr};
            end else begin
              nr_d    = cur_q;
              wr_addr = ra_q;
              wr_data = {cur_q, sa_q, ta_q};
            end
            div_start = 1'b1;
            state_d   = S_DIV;
          end else begin
            res_root_d = ra_q;
            res_size_d = sa_q;
            state_d    = S_RESP;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_parent;
          cur_d   = rd_parent;
        end
      end

      // Wait for c / size, then update the new root
      S_DIV: begin
        if (div_done) begin
          we           = 1'b1;
          wr_addr      = nr_q;
          wr_data      = {nr_q, sz_q, thr_new};
          res_merged_d = 1'b1;
          res_root_d   = nr_q;
          res_size_d   = sz_q;
          state_d      = S_RESP;
        end
      end

      S_RESP: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      merge_c_q   <= MERGE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) merge_c_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    find_only_q  <= find_only_d;
    vb_q         <= vb_d;
    w_q          <= w_d;
    last_q       <= last_d;
    cur_q        <= cur_d;
    ra_q         <= ra_d;
    sa_q         <= sa_d;
    ta_q         <= ta_d;
    nr_q         <= nr_d;
    sz_q         <= sz_d;
    idx_q        <= idx_d;
    res_merged_q <= res_merged_d;
    res_root_q   <= res_root_d;
    res_size_q   <= res_size_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_merged_q <= res_merged_q;
      out_root_q   <= VERTEX_W'(res_root_q);
      out_size_q   <= COUNT_W'(res_size_q);
      out_done_q   <= last_q;
      out_status_q <= res_status_q;
    end
  end

  // Store ports
  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
  end

  assign out_valid_o      = out_valid_q;
  assign merged_o         = out_merged_q;
  assign root_o           = out_root_q;
  assign component_size_o = out_size_q;
  assign done_res_o       = out_done_q;
  assign status_o         = out_status_q;

endmodule
`default_nettype wire

/* rtl/gsuf_checker.sv */
`default_nettype none
module gsuf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          merged_o,
  input logic [gsuf_pkg::VERTEX_W-1:0] root_o,
  input logic [gsuf_pkg::COUNT_W-1:0]  component_size_o,
  input logic                          status_o
);
  import gsuf_pkg::*;

  // Stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Stalled result keeps its fields
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(root_o) && $stable(component_size_o)
                                   && $stable(merged_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Ignored item reports nothing
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !merged_o && root_o == '0 && component_size_o == '0)
    else $error("ignored item carries data");

  // A join leaves at least two vertices in the component
  a_join_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && merged_o |-> !status_o && component_size_o >= COUNT_W'(2))
    else $error("join with too small a component");

endmodule

bind graph_segment_union_find_core gsuf_checker u_gsuf_checker (.*);
`default_nettype wire

/* test/tb_graph_segment_union_find_core.sv */
module tb_graph_segment_union_find_core;
  import gsuf_pkg::*;

  localparam int unsigned MAXV = 1024;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    op_e              op;
    logic [VERTEX_W-1:0] va;
    logic [VERTEX_W-1:0] vb;
    logic [WEIGHT_W-1:0] wt;
    logic [COUNT_W-1:0]  cnt;
    logic                last;
  } item_t;

  typedef struct packed {
    logic                merged;
    logic [VERTEX_W-1:0] root;
    logic [COUNT_W-1:0]  csize;
    logic                done;
    logic                status;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    chk;
    result_t res;
  } row_t;

  localparam int NROWS = 20;
  localparam row_t DIRECTED [NROWS] = '{
    '{'{OP_EDGE,  10'd0,    10'd1,    16'd0,      11'd0,    1'b0}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b0, 1'b1}},
    '{'{OP_FIND,  10'd1023, 10'd0,    16'hFFFF,   11'd0,    1'b1}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b1, 1'b1}},
    '{'{OP_START, 10'd0,    10'd0,    16'd0,      11'd0,    1'b0}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b0, 1'b0}},
    '{'{OP_FIND,  10'd0,    10'd0,    16'd0,      11'd0,    1'b0}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b0, 1'b1}},
    '{'{OP_START, 10'd1023, 10'd1023, 16'hFFFF,   11'd2047, 1'b1}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b1, 1'b0}},
    '{'{OP_FIND,  10'd1023, 10'd0,    16'd0,      11'd0,    1'b0}, 1'b1, '{1'b0, 10'd1023, 11'd1, 1'b0, 1'b0}},
    '{'{OP_EDGE,  10'd1023, 10'd1022, 16'd0,      11'd0,    1'b0}, 1'b1, '{1'b1, 10'd1022, 11'd2, 1'b0, 1'b0}},
    '{'{OP_START, 10'd0,    10'd0,    16'd0,      11'd8,    1'b0}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b0, 1'b0}},
    '{'{OP_EDGE,  10'd0,    10'd1,    16'd256,    11'd0,    1'b0}, 1'b1, '{1'b1, 10'd1,    11'd2, 1'b0, 1'b0}},
    '{'{OP_EDGE,  10'd2,    10'd3,    16'd257,    11'd0,    1'b0}, 1'b1, '{1'b0, 10'd2,    11'd1, 1'b0, 1'b0}},
    '{'{OP_EDGE,  10'd0,    10'd1,    16'd300,    11'd0,    1'b0}, 1'b1, '{1'b0, 10'd1,    11'd2, 1'b0, 1'b0}},
    '{'{OP_EDGE,  10'd8,    10'd0,    16'd0,      11'd0,    1'b0}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b0, 1'b1}},
    '{'{OP_EDGE,  10'd0,    10'd8,    16'd0,      11'd0,    1'b0}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b0, 1'b1}},
    '{'{OP_FIND,  10'd8,    10'd0,    16'd0,      11'd0,    1'b0}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b0, 1'b1}},
    '{'{OP_NONE,  10'd5,    10'd6,    16'hFFFF,   11'd2047, 1'b1}, 1'b1, '{1'b0, 10'd0,    11'd0, 1'b1, 1'b0}},
    '{'{OP_EDGE,  10'd1,    10'd2,    16'd0,      11'd0,    1'b0}, 1'b1, '{1'b1, 10'd1,    11'd3, 1'b0, 1'b0}},
    '{'{OP_EDGE,  10'd3,    10'd4,    16'hFFFF,   11'd0,    1'b0}, 1'b1, '{1'b0, 10'd3,    11'd1, 1'b0, 1'b0}},
    '{'{OP_FIND,  10'd0,    10'd0,    16'd0,      11'd0,    1'b0}, 1'b0, '0},
    '{'{OP_START, 10'd0,    10'd0,    16'd0,      11'd1024, 1'b0}, 1'b0, '0},
    '{'{OP_EDGE,  10'd1023, 10'd0,    16'd128,    11'd0,    1'b1}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  op_e  op_i;
  logic [VERTEX_W-1:0] vertex_a_i;
  logic [VERTEX_W-1:0] vertex_b_i;
  logic [WEIGHT_W-1:0] weight_i;
  logic [COUNT_W-1:0]  vertex_count_i;
  logic last_edge_i;
  logic out_valid_o;
  logic out_stall_i;
  logic merged_o;
  logic [VERTEX_W-1:0] root_o;
  logic [COUNT_W-1:0]  component_size_o;
  logic done_res_o;
  logic status_o;
  logic cfg_we_i;
  logic [THR_W-1:0] cfg_wdata_i;

  graph_segment_union_find_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .vertex_a_i, .vertex_b_i,
    .weight_i, .vertex_count_i, .last_edge_i, .out_valid_o, .out_stall_i, .merged_o,
    .root_o, .component_size_o, .done_res_o, .status_o, .cfg_we_i, .cfg_wdata_i
  );

  // Shadow of the segmentation state
  int unsigned parent_mem [MAXV];
  int unsigned size_mem [MAXV];
  int unsigned thr_mem [MAXV];
  int unsigned active_cnt;
  int unsigned merge_c;

  result_t expected_results [$];
  int unsigned fails;
  bit quiet;
  int unsigned stall_cnt;
  int unsigned cycles;

  function automatic int unsigned root_of(int unsigned v);
    int unsigned steps;
    for (steps = 0; steps < MAXV; steps++) begin
      if (parent_mem[v] == v) return v;
      v = parent_mem[v];
    end
    return v;
  endfunction

  function automatic void open_graph(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      parent_mem[i] = i;
      size_mem[i] = 1;
      thr_mem[i] = merge_c;
    end
  endfunction

  // Apply one item to the shadow state and return its result
  function automatic result_t segment_step(item_t it);
    result_t r;
    int unsigned ra, rb, nr, child, sz, t, n;
    r = '0;
    r.done = it.last;
    case (it.op)
      OP_START: begin
        n = (it.cnt > MAXV) ? MAXV : it.cnt;
        open_graph(n);
        active_cnt = n;
      end
      OP_EDGE: begin
        if (it.va >= active_cnt || it.vb >= active_cnt) begin
          r.status = 1'b1;
        end else begin
          ra = root_of(it.va);
          rb = root_of(it.vb);
          nr = ra;
          if (ra != rb && it.wt <= thr_mem[ra] && it.wt <= thr_mem[rb]) begin
            if (size_mem[ra] > size_mem[rb]) begin
              nr = ra;
              child = rb;
            end else begin
              nr = rb;
              child = ra;
            end
            parent_mem[child] = nr;
            sz = size_mem[nr] + size_mem[child];
            size_mem[nr] = sz;
            t = it.wt + merge_c / sz;
            thr_mem[nr] = (t > THR_MAX) ? THR_MAX : t;
            r.merged = 1'b1;
          end
          r.root = VERTEX_W'(nr);
          r.csize = COUNT_W'(size_mem[nr]);
        end
      end
      OP_FIND: begin
        if (it.va >= active_cnt) begin
          r.status = 1'b1;
        end else begin
          r.root = VERTEX_W'(root_of(it.va));
          r.csize = COUNT_W'(size_mem[r.root]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stall per item, compare against the oldest expectation
  always @(posedge clk_i) begin
    int unsigned nxt;
    result_t e;
    if (!rst_ni) begin
      nxt = 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result root=%0d", root_o);
        fails++;
      end else begin
        e = expected_results.pop_front();
        if (merged_o !== e.merged) begin
          $error("merged: expected %0d actual %0d", e.merged, merged_o); fails++;
        end
        if (root_o !== e.root) begin
          $error("root: expected %0d actual %0d", e.root, root_o); fails++;
        end
        if (component_size_o !== e.csize) begin
          $error("component_size: expected %0d actual %0d", e.csize, component_size_o);
          fails++;
        end
        if (done_res_o !== e.done) begin
          $error("done_res: expected %0d actual %0d", e.done, done_res_o); fails++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status_o); fails++;
        end
      end
      nxt = quiet ? 0 : $urandom_range(0, 3);
    end else begin
      nxt = (stall_cnt > 0) ? stall_cnt - 1 : 0;
    end
    stall_cnt <= nxt;
    out_stall_i <= (nxt != 0);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_graph_segment_union_find_core NOT OK");
      $finish;
    end
  end

  // Hold off, present one item, wait for it to be taken, then predict
  task automatic send(item_t it);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= it.op;
    vertex_a_i <= it.va;
    vertex_b_i <= it.vb;
    weight_i <= it.wt;
    vertex_count_i <= it.cnt;
    last_edge_i <= it.last;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(segment_step(it));
  endtask

  // Drain outstanding results, then write the merge constant
  task automatic write_merge_c(logic [THR_W-1:0] v);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    merge_c = {8'd0, v};
  endtask

  function automatic item_t rand_item();
    item_t it;
    int unsigned pick;
    it.va = VERTEX_W'($urandom);
    it.vb = VERTEX_W'($urandom);
    it.wt = WEIGHT_W'($urandom);
    it.cnt = COUNT_W'($urandom);
    it.last = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    it.op = (pick < 75) ? OP_EDGE : (pick < 95) ? OP_FIND : (pick < 98) ? OP_NONE : OP_START;
    if (it.op == OP_START) it.cnt = COUNT_W'($urandom_range(1, 40));
    if (active_cnt != 0 && $urandom_range(0, 9) != 0) begin
      it.va = VERTEX_W'($urandom_range(0, active_cnt - 1));
      it.vb = VERTEX_W'($urandom_range(0, active_cnt - 1));
    end
    return it;
  endfunction

  initial begin
    item_t it;
    result_t got;
    int unsigned wacc, step, cnt;
    logic [THR_W-1:0] mc;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_NONE;
    vertex_a_i = '0;
    vertex_b_i = '0;
    weight_i = '0;
    vertex_count_i = '0;
    last_edge_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    fails = 0;
    cycles = 0;
    stall_cnt = 0;
    quiet = 1'b0;
    merge_c = {8'd0, MERGE_RESET};
    open_graph(MAXV);
    active_cnt = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; typed expectations override the prediction where given
    foreach (DIRECTED[i]) begin
      send(DIRECTED[i].it);
      if (DIRECTED[i].chk) begin
        got = expected_results[$];
        if (got !== DIRECTED[i].res) begin
          $error("row %0d: expected %h predicted %h", i, DIRECTED[i].res, got);
          fails++;
        end
        expected_results[$] = DIRECTED[i].res;
      end
    end

    // Random phases, each under its own merge constant
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: mc = THR_MAX;
        1: mc = '0;
        2: mc = MERGE_RESET;
        3: mc = 24'h000001;
        default: mc = THR_W'($urandom_range(0, 24'h00FFFF));
      endcase
      write_merge_c(mc);
      quiet = (ph % 4 == 3);
      cnt = (ph == 5) ? 1024 : (ph == 6) ? 0 : $urandom_range(1, 40);
      it = rand_item();
      it.op = OP_START;
      it.cnt = COUNT_W'(cnt);
      send(it);
      wacc = 0;
      step = (mc >> 4) + 2;
      if (step > 4000) step = 4000;
      for (int k = 0; k < 75; k++) begin
        it = rand_item();
        // Mostly ascending weights; some noise weights stay random
        if (it.op == OP_EDGE && $urandom_range(0, 9) != 0) begin
          wacc = wacc + $urandom_range(0, step);
          if (wacc > 16'hFFFF) wacc = $urandom_range(0, 255);
          it.wt = WEIGHT_W'(wacc);
        end
        send(it);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_graph_segment_union_find_core OK");
    end else begin
      $display("tb_graph_segment_union_find_core NOT OK");
    end
    $finish;
  end

endmodule
